// File: sv/light_sensor_grow_lamp_controller_core_defines.svh
// Assertion macros for the grow lamp controller RTL.
`ifndef LIGHT_SENSOR_GROW_LAMP_CONTROLLER_CORE_DEFINES_SVH
`define LIGHT_SENSOR_GROW_LAMP_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is held
`define LGLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lglc assertion failed");

// Clocked check that also holds during reset
`define LGLC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lglc assertion failed");

`else

`define LGLC_ASSERT(lbl, clk, rst_n, prop)
`define LGLC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: sv/lglc_pkg.sv
`default_nettype none

package lglc_pkg;

  // Fixed field widths
  localparam int RAW_W    = 16;
  localparam int MANT_W   = 12;
  localparam int EXP_W    = 4;
  localparam int LIGHT_W  = 17;
  localparam int LEVEL_W  = 10;
  localparam int CLASS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Exponent that leaves the mantissa unshifted
  localparam logic [EXP_W-1:0] EXP_UNITY = 4'd6;

  // Largest storable brightness
  localparam logic [LEVEL_W-1:0] LEVEL_SAT = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL    = 1'b1;

  // Item action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_POWER  = 1'b1;

  // Light classes
  localparam logic [CLASS_W-1:0] CLASS_DARK   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_BRIGHT = 2'd2;

  // Reset value of the threshold register
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 10'd500;

  typedef struct packed {
    logic             action;
    logic [RAW_W-1:0] raw_reading;
    logic             power_request;
  } in_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] scaled_light;
    logic [CLASS_W-1:0] light_class;
    logic [LEVEL_W-1:0] lamp_level;
    logic               lamp_on;
    logic               item_applied;
  } out_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: sv/lglc_divider.sv
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle, numerator
// shifted in MSB first.
module lglc_divider #(
  parameter int NUM_W = 26
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [NUM_W-1:0]                  num,
  input  wire logic [lglc_pkg::LEVEL_W-1:0]      den,
  output logic [NUM_W-1:0]                       quo,
  output lglc_pkg::div_stat_t                    stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DEN_W = lglc_pkg::LEVEL_W;

  logic [NUM_W-1:0] num_sh_r, num_sh_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_try;
  logic [DEN_W:0]   rem_sub;
  logic             busy;

  assign busy    = (cnt_r != '0);
  assign rem_try = {rem_r, num_sh_r[NUM_W-1]};
  assign rem_sub = rem_try - {1'b0, den_r};

  // One restoring step per busy cycle
  always_comb begin
    num_sh_nxt = num_sh_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    if (start) begin
      num_sh_nxt = num;
      quo_nxt    = '0;
      rem_nxt    = '0;
      den_nxt    = den;
      cnt_nxt    = CNT_W'(NUM_W);
    end else if (busy) begin
      num_sh_nxt = {num_sh_r[NUM_W-2:0], 1'b0};
      if (rem_try >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_try[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    num_sh_r <= num_sh_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: sv/light_sensor_grow_lamp_controller_core.sv
`default_nettype none

// Grow lamp controller. Each transaction on the input channel is a sensor
// sample or a manual power command and yields exactly one result
// transaction. A power command, a sample in manual mode, or a sample at or
// above the threshold goes from S_IDLE to S_OUT, which loads it into the
// output register; the block is back in S_IDLE before it takes the next
// transaction. An automatic sample below the threshold goes through a
// bit-serial divider that computes (threshold - light) * MAX_LEVEL /
// threshold one quotient bit per cycle. It passes S_MUL, where the divider
// is loaded, and S_DIV, where the divider runs, before S_OUT loads the
// result into the output register. A result that is still stalled in the
// output register holds the next result back, and with it the input. One
// transaction is in flight at a time; a finished result waits in the output
// register while the next one is accepted. Configuration writes are always
// ready and must be issued only while no transaction is in flight.
module light_sensor_grow_lamp_controller_core #(
  parameter int MAX_LEVEL = 1000,
  parameter int MIN_LEVEL = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lglc_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lglc_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lglc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lglc_pkg::LEVEL_W-1:0]      cfg_data
);

`include "light_sensor_grow_lamp_controller_core_defines.svh"

  localparam int LW    = lglc_pkg::LEVEL_W;
  localparam int LIW   = lglc_pkg::LIGHT_W;
  localparam int MAX_W = $clog2(MAX_LEVEL + 1);
  localparam int NUM_W = LW + MAX_W;

  localparam logic [MAX_W-1:0] MAX_C     = MAX_W'(MAX_LEVEL);
  localparam logic [LIW-1:0]   MAX_LIGHT = LIW'(MAX_LEVEL);
  localparam logic [LIW-1:0]   MIN_LIGHT = LIW'(MIN_LEVEL);
  localparam logic [LW-1:0]    MIN_TH    = LW'(MIN_LEVEL);
  localparam logic [LW-1:0]    MAX_TH    = LW'(MAX_LEVEL);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LW-1:0]       th_r;
  logic                man_r;
  logic                lamp_on_r, lamp_on_nxt;
  logic [LW-1:0]       lamp_level_r, lamp_level_nxt;
  logic                act_r, req_r, item_man_r;
  logic [LIW-1:0]      light_r;
  logic [1:0]          cls_r;
  logic [LW-1:0]       diff_r;
  logic [LW-1:0]       bright_r;
  logic                out_valid_r;
  lglc_pkg::out_t      out_r;
  logic                in_fire;
  logic                out_load;
  logic                applied;
  logic [LIW-1:0]      scaled;
  logic [1:0]          cls;
  logic                need_div;
  logic [LIW-1:0]      cfg_ext;
  logic [LW-1:0]       th_clamped;
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [NUM_W-1:0]    div_quo;
  lglc_pkg::div_stat_t div_stat;
  logic [LW-1:0]       quo_sat;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Threshold write clamp
  assign cfg_ext = {{(LIW-LW){1'b0}}, cfg_data};
  always_comb begin
    if (cfg_ext < MIN_LIGHT) begin
      th_clamped = MIN_TH;
    end else if (cfg_ext > MAX_LIGHT) begin
      th_clamped = MAX_TH;
    end else begin
      th_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_r  <= lglc_pkg::THRESHOLD_RST;
      man_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lglc_pkg::CFG_THRESHOLD: th_r  <= th_clamped;
        lglc_pkg::CFG_MANUAL:    man_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Exponent scaling of the mantissa
  always_comb begin
    logic [lglc_pkg::EXP_W-1:0] ex;
    logic [LIW-1:0]             mant;
    ex   = in_data.raw_reading[lglc_pkg::RAW_W-1:lglc_pkg::MANT_W];
    mant = {{(LIW-lglc_pkg::MANT_W){1'b0}}, in_data.raw_reading[lglc_pkg::MANT_W-1:0]};
    case (ex)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: scaled = mant >> (lglc_pkg::EXP_UNITY - ex);
      4'd7, 4'd8, 4'd9, 4'd10, 4'd11:     scaled = mant << (ex - lglc_pkg::EXP_UNITY);
      default:                            scaled = mant;
    endcase
  end

  // Light class
  always_comb begin
    if (scaled < MIN_LIGHT) begin
      cls = lglc_pkg::CLASS_DARK;
    end else if (scaled < MAX_LIGHT) begin
      cls = lglc_pkg::CLASS_MEDIUM;
    end else begin
      cls = lglc_pkg::CLASS_BRIGHT;
    end
  end

  assign need_div = (in_data.action == lglc_pkg::ACT_SAMPLE) && !man_r &&
                    (scaled < {{(LIW-LW){1'b0}}, th_r});

  // Numerator formed straight into the divider's shift register
  assign div_start = (state_r == S_MUL);
  assign div_num   = {{MAX_W{1'b0}}, diff_r} * {{LW{1'b0}}, MAX_C};

  lglc_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (th_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign quo_sat = (|div_quo[NUM_W-1:LW]) ? lglc_pkg::LEVEL_SAT : div_quo[LW-1:0];

  // Sequencer
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = need_div ? S_MUL : S_OUT;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Lamp state after the item
  always_comb begin
    lamp_on_nxt    = lamp_on_r;
    lamp_level_nxt = lamp_level_r;
    applied        = 1'b0;
    if (act_r == lglc_pkg::ACT_SAMPLE && !item_man_r) begin
      lamp_level_nxt = bright_r;
      lamp_on_nxt    = (bright_r != '0);
      applied        = 1'b1;
    end else if (act_r == lglc_pkg::ACT_POWER && item_man_r) begin
      lamp_on_nxt = req_r;
      applied     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lamp_on_r    <= 1'b0;
      lamp_level_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        lamp_on_r    <= lamp_on_nxt;
        lamp_level_r <= lamp_level_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r      <= in_data.action;
      req_r      <= in_data.power_request;
      item_man_r <= man_r;
      light_r    <= (in_data.action == lglc_pkg::ACT_SAMPLE) ? scaled : '0;
      cls_r      <= (in_data.action == lglc_pkg::ACT_SAMPLE) ? cls : lglc_pkg::CLASS_DARK;
      diff_r     <= th_r - scaled[LW-1:0];
      bright_r   <= '0;
    end else if (state_r == S_DIV && div_stat.done) begin
      bright_r <= quo_sat;
    end
    if (out_load) begin
      out_r.scaled_light <= light_r;
      out_r.light_class  <= cls_r;
      out_r.lamp_level   <= lamp_level_nxt;
      out_r.lamp_on      <= lamp_on_nxt;
      out_r.item_applied <= applied;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `LGLC_ASSERT(a_div_done_to_out, clk, rst_n,
    (state_r == S_DIV && div_stat.done) |=> (state_r == S_OUT))
  `LGLC_ASSERT(a_div_done_in_div, clk, rst_n, div_stat.done |-> (state_r == S_DIV))
  `LGLC_ASSERT(a_auto_lamp_on, clk, rst_n,
    (out_load && act_r == lglc_pkg::ACT_SAMPLE && !item_man_r) |=>
      (out_r.lamp_on == (out_r.lamp_level != '0)))
  `LGLC_ASSERT(a_start_idle_div, clk, rst_n, div_start |-> !div_stat.busy)

endmodule

`default_nettype wire

// File: verif/lamp_result_checker.sv
`timescale 1ns / 100ps

// Watches the input, result and register channels of the grow lamp
// controller, predicts one result per accepted input transaction and
// compares every accepted result against the oldest prediction.
module lamp_result_checker #(
  parameter int MAX_LEVEL = 1000,
  parameter int MIN_LEVEL = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  lglc_pkg::in_t                    in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  lglc_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lglc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lglc_pkg::LEVEL_W-1:0]     cfg_data,
  output int                               fail_cnt,
  output int                               pending
);

  import lglc_pkg::*;

  // Highest exponent that still shifts left
  localparam int unsigned EXP_SHIFT_TOP = 11;

  localparam logic [LEVEL_W-1:0] LVL_MIN = LEVEL_W'(MIN_LEVEL);
  localparam logic [LEVEL_W-1:0] LVL_MAX = LEVEL_W'(MAX_LEVEL);

  // Shadow copies of the registers and the lamp state
  logic [LEVEL_W-1:0] thr_shadow;
  logic               manual_shadow;
  logic [LEVEL_W-1:0] lamp_level_shadow;
  logic               lamp_on_shadow;

  // Predicted results in acceptance order
  out_t lamp_result_q[$];

  // Mantissa times two to the power (exponent - 6); exponents above 11 leave it unscaled
  function automatic logic [LIGHT_W-1:0] scale_light(logic [RAW_W-1:0] raw);
    logic [LIGHT_W-1:0] mant;
    logic [EXP_W-1:0]   ex;
    mant = {{(LIGHT_W-MANT_W){1'b0}}, raw[MANT_W-1:0]};
    ex   = raw[RAW_W-1:MANT_W];
    if (ex < EXP_UNITY) return mant >> (EXP_UNITY - ex);
    if (ex <= EXP_SHIFT_TOP) return mant << (ex - EXP_UNITY);
    return mant;
  endfunction

  function automatic logic [CLASS_W-1:0] light_band(logic [LIGHT_W-1:0] light);
    if (light < MIN_LEVEL) return CLASS_DARK;
    if (light < MAX_LEVEL) return CLASS_MEDIUM;
    return CLASS_BRIGHT;
  endfunction

  // Brightness falls linearly from MAX_LEVEL at no light to 0 at threshold
  function automatic logic [LEVEL_W-1:0] dim_level(logic [LIGHT_W-1:0] light);
    longint unsigned th;
    longint unsigned lt;
    longint unsigned q;
    th = thr_shadow;
    lt = light;
    if (th == 0 || lt >= th) return '0;
    q = (th - lt) * MAX_LEVEL / th;
    if (q > LEVEL_SAT) q = LEVEL_SAT;
    return q[LEVEL_W-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] clamp_threshold(logic [LEVEL_W-1:0] v);
    if (v < MIN_LEVEL) return LVL_MIN;
    if (v > MAX_LEVEL) return LVL_MAX;
    return v;
  endfunction

  // Applies one transaction to the shadow state and builds its result
  function automatic out_t lamp_response(in_t it);
    out_t r;
    r = '0;
    if (it.action == ACT_SAMPLE) begin
      r.scaled_light = scale_light(it.raw_reading);
      r.light_class  = light_band(r.scaled_light);
      if (!manual_shadow) begin
        lamp_level_shadow = dim_level(r.scaled_light);
        lamp_on_shadow    = (lamp_level_shadow != '0);
        r.item_applied    = 1'b1;
      end
    end else if (manual_shadow) begin
      lamp_on_shadow = it.power_request;
      r.item_applied = 1'b1;
    end
    r.lamp_level = lamp_level_shadow;
    r.lamp_on    = lamp_on_shadow;
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Monitor: registers first, then results, then new transactions
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      thr_shadow        = THRESHOLD_RST;
      manual_shadow     = 1'b0;
      lamp_level_shadow = '0;
      lamp_on_shadow    = 1'b0;
      lamp_result_q.delete();
      fail_cnt          = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_shadow = clamp_threshold(cfg_data);
          CFG_MANUAL: manual_shadow = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (lamp_result_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = lamp_result_q.pop_front();
          check_field("scaled_light", want.scaled_light, out_data.scaled_light);
          check_field("light_class", want.light_class, out_data.light_class);
          check_field("lamp_level", want.lamp_level, out_data.lamp_level);
          check_field("lamp_on", want.lamp_on, out_data.lamp_on);
          check_field("item_applied", want.item_applied, out_data.item_applied);
        end
      end
      if (in_valid && !in_stall) lamp_result_q.push_back(lamp_response(in_data));
    end
    pending = lamp_result_q.size();
  end

endmodule

// File: verif/tb_light_sensor_grow_lamp_controller_core.sv
`timescale 1ns / 100ps

module tb_light_sensor_grow_lamp_controller_core;

  import lglc_pkg::*;

  localparam int LAMP_MAX_LEVEL = 1000;
  localparam int LAMP_MIN_LEVEL = 10;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int PRESSURE_PHASE = 5;
  localparam int QUIET_PHASE    = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TIMEOUT_NS     = 5_000_000;

  typedef enum logic [1:0] {SINK_RANDOM, SINK_QUIET, SINK_HOLD} sink_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_data;
  int                   fail_cnt;
  int                   pending;

  bit         src_idle;
  bit         hold_done;
  sink_mode_t sink_mode;

  always #5 clk = ~clk;

  light_sensor_grow_lamp_controller_core #(
    .MAX_LEVEL(LAMP_MAX_LEVEL),
    .MIN_LEVEL(LAMP_MIN_LEVEL)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lamp_result_checker #(
    .MAX_LEVEL(LAMP_MAX_LEVEL),
    .MIN_LEVEL(LAMP_MIN_LEVEL)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_cnt(fail_cnt),
    .pending(pending)
  );

  // Sensor sample with a given exponent and mantissa
  function automatic in_t sample_of(logic [EXP_W-1:0] ex, logic [MANT_W-1:0] mant);
    in_t it;
    it.action        = ACT_SAMPLE;
    it.raw_reading   = {ex, mant};
    it.power_request = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_t power_of(logic req);
    in_t it;
    it.action        = ACT_POWER;
    it.raw_reading   = RAW_W'($urandom);
    it.power_request = req;
    return it;
  endfunction

  // Random transaction, biased toward light levels around the threshold
  function automatic in_t random_item(bit manual);
    in_t         it;
    int unsigned pick;
    if (manual) it.action = $urandom_range(0, 1) ? ACT_POWER : ACT_SAMPLE;
    else it.action = ($urandom_range(0, 4) == 0) ? ACT_POWER : ACT_SAMPLE;
    it.power_request = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 7);
    case (pick)
      0, 1, 2: it.raw_reading = RAW_W'($urandom);
      3, 4, 5: begin
        it.raw_reading[RAW_W-1:MANT_W] = EXP_UNITY;
        it.raw_reading[MANT_W-1:0]     = MANT_W'($urandom_range(0, 1100));
      end
      6: begin
        it.raw_reading[RAW_W-1:MANT_W] = EXP_W'($urandom_range(0, 15));
        it.raw_reading[MANT_W-1:0]     = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      end
      default: begin
        it.raw_reading[RAW_W-1:MANT_W] = EXP_W'($urandom_range(7, 11));
        it.raw_reading[MANT_W-1:0]     = MANT_W'($urandom_range(0, 255));
      end
    endcase
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_t it);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every predicted result, up to DRAIN_LIMIT, then let the block settle
  task automatic drain();
    int w;
    in_valid <= 1'b0;
    w = 0;
    while (pending != 0 && w < DRAIN_LIMIT) begin
      @(negedge clk);
      w++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side stall control
  initial begin : sink_ctl
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_mode == SINK_HOLD && !hold_done) begin
        // long hold-off so the block backs up into the input channel
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (sink_mode == SINK_RANDOM && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [LEVEL_W-1:0] thr_val;
    bit                 manual;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data  = '0;
    src_idle  = 1'b1;
    sink_mode = SINK_RANDOM;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: automatic mode at the reset threshold
    write_reg(CFG_THRESHOLD, THRESHOLD_RST);
    write_reg(CFG_MANUAL, LEVEL_W'(1'b0));
    send_item(sample_of(4'd0, 12'h000));
    send_item(sample_of(4'd15, 12'hFFF));
    send_item(sample_of(4'd0, 12'hFFF));
    send_item(sample_of(4'd5, 12'hFFF));
    send_item(sample_of(EXP_UNITY, 12'd499));
    send_item(sample_of(EXP_UNITY, 12'd500));
    send_item(sample_of(4'd11, 12'hFFF));
    send_item(sample_of(4'd7, 12'd1));
    send_item(sample_of(4'd12, 12'd9));
    send_item(sample_of(EXP_UNITY, 12'd10));
    send_item(sample_of(EXP_UNITY, 12'd999));
    send_item(sample_of(EXP_UNITY, 12'd1000));
    send_item(sample_of(EXP_UNITY, 12'd1));
    // power commands are ignored in automatic mode
    send_item(power_of(1'b1));
    send_item(power_of(1'b0));
    drain();

    // Directed: manual mode keeps the brightness, commands drive the flag
    write_reg(CFG_MANUAL, LEVEL_W'(1'b1));
    send_item(power_of(1'b1));
    send_item(power_of(1'b1));
    send_item(sample_of(EXP_UNITY, 12'd0));
    send_item(power_of(1'b0));
    send_item(sample_of(4'd9, 12'hFFF));
    drain();

    // Directed: threshold writes below and above the legal range
    write_reg(CFG_THRESHOLD, 10'd0);
    write_reg(CFG_MANUAL, LEVEL_W'(1'b0));
    send_item(sample_of(EXP_UNITY, 12'd9));
    send_item(sample_of(EXP_UNITY, 12'd0));
    send_item(sample_of(4'd13, 12'hFFF));
    drain();
    write_reg(CFG_THRESHOLD, 10'h3FF);
    send_item(sample_of(EXP_UNITY, 12'd999));
    send_item(sample_of(EXP_UNITY, 12'd0));
    drain();

    // Random phases, each with its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 6)
        0: thr_val = 10'd5;
        1: thr_val = LEVEL_W'(LAMP_MIN_LEVEL);
        2: thr_val = LEVEL_W'(LAMP_MAX_LEVEL);
        3: thr_val = 10'h3FF;
        4: thr_val = 10'd0;
        default: thr_val = LEVEL_W'($urandom_range(11, 999));
      endcase
      manual = (phase % 3 == 2);
      write_reg(CFG_THRESHOLD, thr_val);
      write_reg(CFG_MANUAL, LEVEL_W'(manual));
      if (phase == PRESSURE_PHASE) begin
        src_idle  = 1'b0;
        sink_mode = SINK_HOLD;
      end else if (phase >= QUIET_PHASE) begin
        src_idle  = 1'b0;
        sink_mode = SINK_QUIET;
      end else begin
        src_idle  = 1'b1;
        sink_mode = SINK_RANDOM;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(manual));
      drain();
    end

    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_cnt == 0 && pending == 0) begin
      $display("light_sensor_grow_lamp_controller_core regression: pass");
    end else begin
      $display("light_sensor_grow_lamp_controller_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("light_sensor_grow_lamp_controller_core regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/lglc_pkg.sv
sv/lglc_divider.sv
sv/light_sensor_grow_lamp_controller_core.sv
verif/lamp_result_checker.sv
verif/tb_light_sensor_grow_lamp_controller_core.sv
